@@ design/stum_pkg.sv @@
// Shared types and constants for the slot table with identifier match.
package stum_pkg;

    localparam int OP_W      = 3;
    localparam int SLOT_W    = 6;
    localparam int RANK_W    = 6;
    localparam int UID_W     = 64;
    localparam int STATUS_W  = 2;
    localparam int CNT_OUT_W = 7;
    localparam int S_TDATA_W = 144;
    localparam int M_TDATA_W = 144;

    typedef enum logic [OP_W-1:0] {
        OP_SAVE   = 3'd0,
        OP_FIND   = 3'd1,
        OP_DELETE = 3'd2,
        OP_CLEAR  = 3'd3,
        OP_SELECT = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_BAD_SLOT  = 2'd3
    } status_t;

    // where the result slot and identifier come from
    typedef enum logic [1:0] {
        RES_NONE = 2'd0,
        RES_IDX  = 2'd1,
        RES_CMP  = 2'd2
    } res_src_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SAVE_SCAN,
        S_FIND,
        S_FIND_TAIL,
        S_SEL_SCAN,
        S_SEL_WAIT,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic     load;
        logic     idx_inc;
        logic     seen_inc;
        logic     rd_issue;
        logic     save_here;
        logic     do_delete;
        logic     do_clear;
        logic     res_load;
        status_t  res_status;
        res_src_t res_src;
        logic     emit;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic full;
        logic del_bad;
        logic occ_cur;
        logic idx_last;
        logic rank_hit;
        logic hit;
        logic out_free;
    } stat_t;

endpackage

@@ design/stum_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module stum_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/stum_ctrl.sv @@
// Operation sequencer: accepts a command, steps the scans, hands off the result.
module stum_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  stum_pkg::stat_t st,
    output stum_pkg::cmd_t  cmd
);
    stum_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= stum_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd        = '0;
        s_tready   = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            stum_pkg::S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = stum_pkg::S_DISPATCH;
                end
            end
            stum_pkg::S_DISPATCH: begin
                unique case (st.op)
                    stum_pkg::OP_SAVE: begin
                        if (st.full) begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = stum_pkg::ST_FULL;
                            cmd.res_src    = stum_pkg::RES_NONE;
                            state_next     = stum_pkg::S_EMIT;
                        end else begin
                            state_next = stum_pkg::S_SAVE_SCAN;
                        end
                    end
                    stum_pkg::OP_FIND: begin
                        state_next = stum_pkg::S_FIND;
                    end
                    stum_pkg::OP_DELETE: begin
                        cmd.res_load = 1'b1;
                        cmd.res_src  = stum_pkg::RES_NONE;
                        if (st.del_bad) begin
                            cmd.res_status = stum_pkg::ST_BAD_SLOT;
                        end else begin
                            cmd.do_delete  = 1'b1;
                            cmd.res_status = stum_pkg::ST_OK;
                        end
                        state_next = stum_pkg::S_EMIT;
                    end
                    stum_pkg::OP_CLEAR: begin
                        cmd.do_clear   = 1'b1;
                        cmd.res_load   = 1'b1;
                        cmd.res_status = stum_pkg::ST_OK;
                        cmd.res_src    = stum_pkg::RES_NONE;
                        state_next     = stum_pkg::S_EMIT;
                    end
                    stum_pkg::OP_SELECT: begin
                        state_next = stum_pkg::S_SEL_SCAN;
                    end
                    default: begin
                        cmd.res_load   = 1'b1;
                        cmd.res_status = stum_pkg::ST_BAD_SLOT;
                        cmd.res_src    = stum_pkg::RES_NONE;
                        state_next     = stum_pkg::S_EMIT;
                    end
                endcase
            end
            stum_pkg::S_SAVE_SCAN: begin
                // count below capacity guarantees a free slot ahead
                if (!st.occ_cur) begin
                    cmd.save_here  = 1'b1;
                    cmd.res_load   = 1'b1;
                    cmd.res_status = stum_pkg::ST_OK;
                    cmd.res_src    = stum_pkg::RES_IDX;
                    state_next     = stum_pkg::S_EMIT;
                end else begin
                    cmd.idx_inc = 1'b1;
                end
            end
            stum_pkg::S_FIND: begin
                // one read issued per cycle, compared on the registered read data
                cmd.rd_issue = 1'b1;
                cmd.idx_inc  = 1'b1;
                if (st.hit) begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = stum_pkg::ST_OK;
                    cmd.res_src    = stum_pkg::RES_CMP;
                    state_next     = stum_pkg::S_EMIT;
                end else if (st.idx_last) begin
                    state_next = stum_pkg::S_FIND_TAIL;
                end
            end
            stum_pkg::S_FIND_TAIL: begin
                cmd.res_load = 1'b1;
                if (st.hit) begin
                    cmd.res_status = stum_pkg::ST_OK;
                    cmd.res_src    = stum_pkg::RES_CMP;
                end else begin
                    cmd.res_status = stum_pkg::ST_NOT_FOUND;
                    cmd.res_src    = stum_pkg::RES_NONE;
                end
                state_next = stum_pkg::S_EMIT;
            end
            stum_pkg::S_SEL_SCAN: begin
                if (st.occ_cur && st.rank_hit) begin
                    cmd.rd_issue = 1'b1;
                    state_next   = stum_pkg::S_SEL_WAIT;
                end else begin
                    cmd.seen_inc = st.occ_cur;
                    if (st.idx_last) begin
                        cmd.res_load   = 1'b1;
                        cmd.res_status = stum_pkg::ST_NOT_FOUND;
                        cmd.res_src    = stum_pkg::RES_NONE;
                        state_next     = stum_pkg::S_EMIT;
                    end else begin
                        cmd.idx_inc = 1'b1;
                    end
                end
            end
            stum_pkg::S_SEL_WAIT: begin
                cmd.res_load   = 1'b1;
                cmd.res_status = stum_pkg::ST_OK;
                cmd.res_src    = stum_pkg::RES_CMP;
                state_next     = stum_pkg::S_EMIT;
            end
            stum_pkg::S_EMIT: begin
                if (st.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = stum_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = stum_pkg::S_IDLE;
            end
        endcase
    end

endmodule

@@ design/stum_datapath.sv @@
// Datapath: occupancy map, entry count, identifier RAM, scan counters, result register.
module stum_datapath #(
    parameter int SLOTS = 64
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic [stum_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic [stum_pkg::OP_W-1:0]          s_tuser,
    input  stum_pkg::cmd_t                     cmd,
    output stum_pkg::stat_t                    st,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [stum_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic [stum_pkg::STATUS_W-1:0]      m_tuser
);
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int KW = 2 * stum_pkg::UID_W;
    localparam logic [IW-1:0]   LAST_IDX = IW'(SLOTS - 1);
    localparam logic [CW-1:0]   FULL_CNT = CW'(SLOTS);
    localparam logic [IW+5:0]   SLOTS_W  = (IW + 6)'(SLOTS);

    logic [stum_pkg::OP_W-1:0]   op_reg;
    logic [stum_pkg::SLOT_W-1:0] slot_reg;
    logic [stum_pkg::RANK_W-1:0] rank_reg;
    logic [KW-1:0]               key_reg;

    logic [SLOTS-1:0] occ_reg, occ_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [IW-1:0]    idx_reg;
    logic [CW-1:0]    seen_reg;

    logic             cmp_vld_reg;
    logic             cmp_occ_reg;
    logic [IW-1:0]    cmp_idx_reg;
    logic [KW-1:0]    ram_rdata;

    stum_pkg::status_t res_status_reg;
    logic [IW-1:0]     res_slot_reg;
    logic [KW-1:0]     res_uid_reg;

    logic                           m_tvalid_reg;
    logic [stum_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic [stum_pkg::STATUS_W-1:0]  m_tuser_reg;

    logic [IW+5:0] slot_wide;
    logic [IW-1:0] slot_idx;
    logic          slot_in_range;
    logic          slot_occ;
    logic [IW+5:0] res_slot_wide;
    logic [CW+6:0] count_wide;

    stum_ram #(
        .WIDTH(KW),
        .DEPTH(SLOTS)
    ) u_ram (
        .aclk (aclk),
        .we   (cmd.save_here),
        .waddr(idx_reg),
        .wdata(key_reg),
        .re   (cmd.rd_issue),
        .raddr(idx_reg),
        .rdata(ram_rdata)
    );

    // delete target range check
    assign slot_wide     = {{IW{1'b0}}, slot_reg};
    assign slot_idx      = slot_wide[IW-1:0];
    assign slot_in_range = (slot_wide < SLOTS_W);
    assign slot_occ      = slot_in_range ? occ_reg[slot_idx] : 1'b0;

    always_comb begin
        st          = '0;
        st.op       = stum_pkg::op_t'(op_reg);
        st.full     = (count_reg == FULL_CNT);
        st.del_bad  = !slot_occ;
        st.occ_cur  = occ_reg[idx_reg];
        st.idx_last = (idx_reg == LAST_IDX);
        st.rank_hit = ({{6{1'b0}}, seen_reg} == {{CW{1'b0}}, rank_reg});
        st.hit      = cmp_vld_reg && cmp_occ_reg && (ram_rdata == key_reg);
        st.out_free = !m_tvalid_reg || m_tready;
    end

    always_comb begin
        occ_next   = occ_reg;
        count_next = count_reg;
        if (cmd.do_clear) begin
            occ_next   = '0;
            count_next = '0;
        end else if (cmd.save_here) begin
            occ_next[idx_reg] = 1'b1;
            count_next        = count_reg + CW'(1);
        end else if (cmd.do_delete) begin
            occ_next[slot_idx] = 1'b0;
            count_next         = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg      <= '0;
            count_reg    <= '0;
            idx_reg      <= '0;
            seen_reg     <= '0;
            cmp_vld_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            occ_reg     <= occ_next;
            count_reg   <= count_next;
            cmp_vld_reg <= cmd.rd_issue;
            if (cmd.load) begin
                idx_reg  <= '0;
                seen_reg <= '0;
            end else begin
                if (cmd.idx_inc && (idx_reg != LAST_IDX)) begin
                    idx_reg <= idx_reg + IW'(1);
                end
                if (cmd.seen_inc) begin
                    seen_reg <= seen_reg + CW'(1);
                end
            end
            if (cmd.emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign res_slot_wide = {{6{1'b0}}, res_slot_reg};
    assign count_wide    = {{7{1'b0}}, count_reg};

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg   <= s_tuser;
            slot_reg <= s_tdata[5:0];
            rank_reg <= s_tdata[11:6];
            key_reg  <= {s_tdata[75:12], s_tdata[139:76]};
        end
        if (cmd.rd_issue) begin
            cmp_idx_reg <= idx_reg;
            cmp_occ_reg <= occ_reg[idx_reg];
        end
        if (cmd.res_load) begin
            res_status_reg <= cmd.res_status;
            case (cmd.res_src)
                stum_pkg::RES_IDX: begin
                    res_slot_reg <= idx_reg;
                    res_uid_reg  <= '0;
                end
                stum_pkg::RES_CMP: begin
                    res_slot_reg <= cmp_idx_reg;
                    res_uid_reg  <= ram_rdata;
                end
                default: begin
                    res_slot_reg <= '0;
                    res_uid_reg  <= '0;
                end
            endcase
        end
        if (cmd.emit) begin
            m_tuser_reg <= res_status_reg;
            m_tdata_reg <= {3'b000,
                            res_uid_reg[stum_pkg::UID_W-1:0],
                            res_uid_reg[KW-1:stum_pkg::UID_W],
                            count_wide[stum_pkg::CNT_OUT_W-1:0],
                            res_slot_wide[stum_pkg::SLOT_W-1:0]};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // count tracks the map exactly
    a_count_matches_map: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(occ_reg) == 32'(count_reg))
        else $error("entry count differs from occupancy map");

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_CNT)
        else $error("entry count above capacity");

    a_save_free_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.save_here |-> !occ_reg[idx_reg])
        else $error("save onto an occupied slot");

    a_emit_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!m_tvalid_reg || m_tready))
        else $error("result overwritten before transfer");

    a_hit_after_read: assert property (@(posedge aclk) disable iff (!aresetn)
        st.hit |-> $past(cmd.rd_issue))
        else $error("match reported without a read");

endmodule

@@ design/slot_table_with_uid_match_top.sv @@
// Slot table with 128-bit identifier match: top level.
//
// Commands arrive on the s_ channel, one result per command leaves on m_.
// s_tuser carries the opcode (save, find, delete, clear, select); s_tdata
// carries slot, rank and the identifier. m_tuser carries the status and
// m_tdata the slot, the entry count after the operation and the identifier.
// One command is worked at a time. Delete, clear, a save into a full table
// and unused opcodes are decided without a scan. Save scans for the lowest
// free slot; find reads the identifier RAM once per slot, one read per
// cycle, with the compare on the registered read data, and stops at the
// first match or after the last slot; select scans for the occupied slot
// of the given rank, or ends at the last slot when the rank is past the end.
// The next command is accepted as soon as the result sits in the output
// register, even while the receiver stalls; a stalled result holds until
// transferred and the following result waits behind it.
// Reset (aresetn low, synchronous) frees all slots and zeroes the count;
// identifier storage is not cleared, as free slots never match or return data.
module slot_table_with_uid_match_top #(
    parameter int SLOTS = 64
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // slot[5:0], rank[11:6], uid_high[75:12], uid_low[139:76], zero pad
    input  logic [stum_pkg::S_TDATA_W-1:0]   s_tdata,
    // opcode[2:0]
    input  logic [stum_pkg::OP_W-1:0]        s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // slot_out[5:0], entry_count_out[12:6], found_uid_high[76:13],
    // found_uid_low[140:77], zero pad
    output logic [stum_pkg::M_TDATA_W-1:0]   m_tdata,
    // status[1:0]
    output logic [stum_pkg::STATUS_W-1:0]    m_tuser
);
    stum_pkg::cmd_t  cmd;
    stum_pkg::stat_t st;

    stum_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .st      (st),
        .cmd     (cmd)
    );

    stum_datapath #(
        .SLOTS(SLOTS)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .cmd     (cmd),
        .st      (st),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

endmodule
